/* src/substring_search_with_case_mode_unit_macros.svh */
// Assertion macros for the substring search unit.
// Included by the top level; no other dependencies.
`ifndef SUBSTRING_SEARCH_WITH_CASE_MODE_UNIT_MACROS_SVH
`define SUBSTRING_SEARCH_WITH_CASE_MODE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check, masked while reset is asserted
`define SSC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");
// Clocked check that also holds during reset
`define SSC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");
`else
`define SSC_ASSERT(label, clk, rst_n, prop)
`define SSC_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

/* src/ssc_pkg.sv */
// Shared types, constants and the ASCII fold function of the substring search unit.
// No dependencies.
package ssc_pkg;

  localparam int          PATTERN_MAX_DEF = 16;
  localparam longint unsigned TEXT_MAX_DEF = 64'd65536;

  localparam int BYTE_W      = 8;
  localparam int OFFSET_W    = 16;
  localparam int LEN_W       = 5;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LO = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HI = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LEN = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CASE_SENS = 2'd3;

  localparam logic [BYTE_W-1:0] ASCII_LOWER_A = 8'h61;
  localparam logic [BYTE_W-1:0] ASCII_LOWER_Z = 8'h7A;
  localparam logic [BYTE_W-1:0] ASCII_CASE_GAP = 8'h20;

  typedef struct packed {
    logic advance;  // take the new hit bit
    logic clear;    // end of text: drop all partial matches
  } cell_ctrl_t;

  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] offset;
  } result_t;

  // Fold a-z to A-Z unless the compare is case sensitive
  function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
                                                  input logic case_sens);
    if (!case_sens && b >= ASCII_LOWER_A && b <= ASCII_LOWER_Z) begin
      return b - ASCII_CASE_GAP;
    end
    return b;
  endfunction

endpackage

/* src/ssc_cell.sv */
// One cell of the match chain: holds the hit bit for one pattern position.
// Depends on ssc_pkg.
module ssc_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ssc_pkg::cell_ctrl_t       ctrl,
  input  logic                      case_sens,
  input  logic [ssc_pkg::BYTE_W-1:0] text_byte,
  input  logic [ssc_pkg::BYTE_W-1:0] pat_byte,
  input  logic                      prev_hit,
  output logic                      hit_nxt,
  output logic                      hit_r
);
  import ssc_pkg::*;

  // Extend the neighbor's partial match when this pattern byte matches
  assign hit_nxt = prev_hit && (fold_byte(pat_byte, case_sens) == text_byte);

  // Hold, advance or clear the hit bit
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      hit_r <= 1'b0;
    end else if (ctrl.advance) begin
      hit_r <= hit_nxt;
    end
  end

endmodule

/* src/ssc_out_buf.sv */
// Two-entry result buffer between the match logic and the result channel.
// Depends on ssc_pkg.
module ssc_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ssc_pkg::result_t  push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_ready,
  output ssc_pkg::result_t  out_data
);
  import ssc_pkg::*;

  result_t    entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       pop;

  assign out_valid = (count_r != 2'd0);
  assign full      = (count_r == 2'd2);
  assign out_data  = entry_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  // Store an incoming result
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* src/substring_search_with_case_mode_unit.sv */
// Top level of the streaming substring search with selectable case mode.
// Depends on ssc_pkg, ssc_cell, ssc_out_buf and the assertion macro header.
//
// Usage:
//   Text bytes enter on the in_ channel (valid/ready), one per transaction,
//   with in_last_byte marking the final byte of a text. Results leave on the
//   out_ channel: out_found=1 with out_match_offset at the first full match,
//   or out_found=0 at the last byte when no match was seen. Bytes after a
//   match give no result; the last byte of a text clears the search state.
//   The cfg_ port writes the pattern words, the pattern length and the case
//   mode; write it only while no text is in flight.
// Timing:
//   One byte per cycle while in_ready is high. The row of PATTERN_MAX match
//   cells compares in the cycle that accepts the byte; the result buffer
//   register then makes the result visible on out_valid in the next cycle when
//   the buffer is empty, and later only while older results wait for the receiver.
// Reset (rst_n low, synchronous) zeroes the configuration, the partial
// matches, the byte count and the done flag, and empties the result buffer.
// Stall: a two-entry result buffer absorbs a stalled receiver; in_ready drops
// only while both entries hold results.
`include "substring_search_with_case_mode_unit_macros.svh"

module substring_search_with_case_mode_unit #(
  parameter int              PATTERN_MAX = ssc_pkg::PATTERN_MAX_DEF,
  parameter longint unsigned TEXT_MAX    = ssc_pkg::TEXT_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration
  input  logic                           cfg_wr_en,
  input  logic [ssc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ssc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // Text input
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ssc_pkg::BYTE_W-1:0]      in_text_byte,
  input  logic                           in_last_byte,
  // Results
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_found,
  output logic [ssc_pkg::OFFSET_W-1:0]    out_match_offset
);
  import ssc_pkg::*;

  localparam int CW = $clog2(TEXT_MAX);
  localparam int DW = (CW > OFFSET_W) ? CW : OFFSET_W;
  localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam logic [CW-1:0] SAT = CW'(TEXT_MAX - 64'd1);

  // Configuration registers
  logic [CFG_DATA_W-1:0] pattern_lo_r;
  logic [CFG_DATA_W-1:0] pattern_hi_r;
  logic [LEN_W-1:0]      pattern_len_r;
  logic                  case_sens_r;

  // Per-text state
  logic [CW-1:0]          bytes_seen_r;
  logic [CW-1:0]          bytes_seen_nxt;
  logic                   done_r;
  logic                   done_nxt;

  logic                   acc;
  logic [BYTE_W-1:0]      text_f;
  logic [LEN_W-1:0]       len_eff;
  logic [IW-1:0]          len_sel;
  logic [PATTERN_MAX-1:0] hit_nxt;
  logic [PATTERN_MAX-1:0] hit_r;
  logic                   match;
  logic [DW-1:0]          off_full;
  cell_ctrl_t             cell_ctrl;
  result_t                res;
  logic                   res_valid;
  logic                   buf_full;
  result_t                out_res;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_lo_r  <= '0;
      pattern_hi_r  <= '0;
      pattern_len_r <= '0;
      case_sens_r   <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_PATTERN_LO:  pattern_lo_r  <= cfg_wdata;
        REG_PATTERN_HI:  pattern_hi_r  <= cfg_wdata;
        REG_PATTERN_LEN: pattern_len_r <= cfg_wdata[LEN_W-1:0];
        REG_CASE_SENS:   case_sens_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_ready = !buf_full;
  assign acc      = in_valid && in_ready;
  assign text_f   = fold_byte(in_text_byte, case_sens_r);

  // Clamp the length to the chain size
  assign len_eff = (pattern_len_r > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : pattern_len_r;
  assign len_sel = IW'(len_eff - LEN_W'(1));

  assign cell_ctrl.advance = acc && !done_r;
  assign cell_ctrl.clear   = acc && in_last_byte;

  // Row of match cells, each fed by its left neighbor
  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    logic [BYTE_W-1:0] pat_byte;
    logic              prev_hit;

    if (i < 8) begin : g_lo
      assign pat_byte = pattern_lo_r[i*BYTE_W +: BYTE_W];
    end else begin : g_hi
      assign pat_byte = pattern_hi_r[(i-8)*BYTE_W +: BYTE_W];
    end

    if (i == 0) begin : g_head
      assign prev_hit = 1'b1;
    end else begin : g_body
      assign prev_hit = hit_r[i-1];
    end

    ssc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (cell_ctrl),
      .case_sens (case_sens_r),
      .text_byte (text_f),
      .pat_byte  (pat_byte),
      .prev_hit  (prev_hit),
      .hit_nxt   (hit_nxt[i]),
      .hit_r     (hit_r[i])
    );
  end

  // Full match at the configured length
  assign match = (len_eff != '0) && hit_nxt[len_sel];

  // Start offset, pinned once the count has saturated
  assign off_full = (bytes_seen_r == SAT) ? DW'(SAT)
                  : (DW'(bytes_seen_r) - DW'(len_eff - LEN_W'(1)));

  assign res_valid  = acc && !done_r && (match || in_last_byte);
  assign res.found  = match;
  assign res.offset = match ? off_full[OFFSET_W-1:0] : '0;

  // Next byte count and done flag
  always_comb begin
    bytes_seen_nxt = bytes_seen_r;
    done_nxt       = done_r;
    if (acc) begin
      if (in_last_byte) begin
        bytes_seen_nxt = '0;
        done_nxt       = 1'b0;
      end else if (!done_r) begin
        if (match) begin
          done_nxt = 1'b1;
        end else if (bytes_seen_r != SAT) begin
          bytes_seen_nxt = bytes_seen_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r <= '0;
      done_r       <= 1'b0;
    end else begin
      bytes_seen_r <= bytes_seen_nxt;
      done_r       <= done_nxt;
    end
  end

  ssc_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res)
  );

  assign out_found        = out_res.found;
  assign out_match_offset = out_res.offset;

  // Checks
  `SSC_ASSERT(a_done_after_match, clk, rst_n,
              (res_valid && res.found && !in_last_byte) |=> done_r)
  `SSC_ASSERT(a_quiet_when_done, clk, rst_n, (acc && done_r) |-> !res_valid)
  `SSC_ASSERT(a_clear_at_last, clk, rst_n,
              (acc && in_last_byte) |=> (bytes_seen_r == '0 && !done_r && hit_r == '0))
  `SSC_ASSERT(a_count_step, clk, rst_n,
              (acc && !in_last_byte && !done_r && !match && bytes_seen_r != SAT)
              |=> (bytes_seen_r == $past(bytes_seen_r) + CW'(1)))
  `SSC_ASSERT_ALWAYS(a_no_push_when_full, clk, !(res_valid && buf_full))

endmodule

/* tb/ssc_search_checker.sv */
`timescale 1ns / 100ps
// Result checker for the substring search unit: tracks register writes and text
// bytes, predicts each result and compares it with the out_ channel. Uses ssc_pkg.
module ssc_search_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [ssc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ssc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [ssc_pkg::BYTE_W-1:0]      in_text_byte,
  input  logic                            in_last_byte,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic                            out_found,
  input  logic [ssc_pkg::OFFSET_W-1:0]    out_match_offset,
  output int                              err_count,
  output int                              results_pending,
  output int                              hit_count,
  output int                              miss_count
);
  import ssc_pkg::*;

  localparam int                  PAT_BYTES = PATTERN_MAX_DEF;
  localparam logic [OFFSET_W-1:0] SEEN_MAX  = OFFSET_W'(TEXT_MAX_DEF - 1);

  // Shadow of the configuration registers
  logic [2*CFG_DATA_W-1:0] pat_word;
  logic [LEN_W-1:0]        pat_len;
  logic                    exact;

  // Per-text search state
  logic [PAT_BYTES-1:0]    partial;
  logic [OFFSET_W-1:0]     seen;
  logic                    done;

  result_t                 due_results[$];
  result_t                 want;

  // Upper-case a-z unless the compare is exact
  function automatic logic [BYTE_W-1:0] upcase(input logic [BYTE_W-1:0] b);
    return (!exact && b >= "a" && b <= "z") ? (b ^ 8'h20) : b;
  endfunction

  function automatic void clear_text();
    partial = '0;
    seen    = '0;
    done    = 1'b0;
  endfunction

  // Advance the search by one text byte and queue the result it causes, if any
  task automatic search_byte(input logic [BYTE_W-1:0] raw, input logic last);
    int                   len;
    logic [PAT_BYTES-1:0] eq;
    logic [BYTE_W-1:0]    b;
    result_t              r;
    len = (pat_len > PAT_BYTES) ? PAT_BYTES : int'(pat_len);
    if (done) begin
      if (last) clear_text();
      return;
    end
    b = upcase(raw);
    for (int i = 0; i < PAT_BYTES; i++) begin
      eq[i] = (upcase(pat_word[8*i +: 8]) == b);
    end
    partial = {partial[PAT_BYTES-2:0], 1'b1} & eq;
    if (len != 0 && partial[len-1]) begin
      r.found  = 1'b1;
      r.offset = (seen == SEEN_MAX) ? SEEN_MAX : seen - OFFSET_W'(len - 1);
      due_results.push_back(r);
      done = 1'b1;
      if (last) clear_text();
    end else if (last) begin
      r.found  = 1'b0;
      r.offset = '0;
      due_results.push_back(r);
      clear_text();
    end else if (seen != SEEN_MAX) begin
      seen++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pat_word   = '0;
      pat_len    = '0;
      exact      = 1'b0;
      clear_text();
      due_results.delete();
      err_count  = 0;
      hit_count  = 0;
      miss_count = 0;
    end else begin
      // Track register writes
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_PATTERN_LO:  pat_word[CFG_DATA_W-1:0] = cfg_wdata;
          REG_PATTERN_HI:  pat_word[2*CFG_DATA_W-1:CFG_DATA_W] = cfg_wdata;
          REG_PATTERN_LEN: pat_len = cfg_wdata[LEN_W-1:0];
          REG_CASE_SENS:   exact = cfg_wdata[0];
          default: ;
        endcase
      end
      // Compare a result transaction with the oldest prediction
      if (out_valid && out_ready) begin
        if (out_found) hit_count++;
        else miss_count++;
        if (due_results.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result: expected none, got found=%0b offset=%0d",
                   $time, out_found, out_match_offset);
        end else begin
          want = due_results.pop_front();
          if (out_found !== want.found) begin
            err_count++;
            $display("%0t: found mismatch: expected %0b, got %0b",
                     $time, want.found, out_found);
          end
          if (out_match_offset !== want.offset) begin
            err_count++;
            $display("%0t: match_offset mismatch: expected %0d, got %0d",
                     $time, want.offset, out_match_offset);
          end
        end
      end
      // Predict from each accepted text byte
      if (in_valid && in_ready) search_byte(in_text_byte, in_last_byte);
    end
    results_pending = due_results.size();
  end

endmodule

/* tb/substring_search_with_case_mode_unit_tb.sv */
`timescale 1ns / 100ps
// Top of the substring search testbench: clock, reset, stimulus and verdict.
// Depends on ssc_pkg, the substring search unit and ssc_search_checker.
module substring_search_with_case_mode_unit_tb;
  import ssc_pkg::*;

  localparam int PAT_BYTES     = PATTERN_MAX_DEF;
  localparam int QUIET_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_ITEMS  = 950;
  localparam int NO_IDLE_BYTES = 200;

  logic                   clk          = 1'b0;
  logic                   rst_n        = 1'b0;
  logic                   cfg_wr_en    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata    = '0;
  logic                   in_valid     = 1'b0;
  logic [BYTE_W-1:0]      in_text_byte = '0;
  logic                   in_last_byte = 1'b0;
  logic                   out_ready    = 1'b0;
  logic                   in_ready;
  logic                   out_valid;
  logic                   out_found;
  logic [OFFSET_W-1:0]    out_match_offset;

  int err_count, results_pending, hit_count, miss_count;
  int quiet         = 0;
  int hold_left     = 0;
  int bytes_sent    = 0;
  int texts_sent    = 0;
  int random_bytes  = 0;
  bit in_idle_on    = 1'b1;
  bit out_idle_on   = 1'b1;
  bit hold_req      = 1'b0;

  // Current pattern as the stimulus sees it
  logic [2*CFG_DATA_W-1:0] pat_now = '0;
  int                      pat_len_now = 0;
  logic [BYTE_W-1:0]       text_buf[$];

  always #5 clk = ~clk;

  substring_search_with_case_mode_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_text_byte     (in_text_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_found        (out_found),
    .out_match_offset (out_match_offset)
  );

  ssc_search_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_text_byte     (in_text_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_found        (out_found),
    .out_match_offset (out_match_offset),
    .err_count        (err_count),
    .results_pending  (results_pending),
    .hit_count        (hit_count),
    .miss_count       (miss_count)
  );

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_req = 1'b0;
    end else begin
      out_ready <= !out_idle_on || ($urandom_range(99) >= 38);
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("%0t: watchdog: no transaction for %0d cycles", $time, quiet);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Swap the case of an ASCII letter half of the time
  function automatic logic [BYTE_W-1:0] flip_case(input logic [BYTE_W-1:0] b);
    if (((b | 8'h20) >= "a") && ((b | 8'h20) <= "z") && $urandom_range(1)) return b ^ 8'h20;
    return b;
  endfunction

  // Mostly pattern bytes and nearby letters, sometimes any byte
  function automatic logic [BYTE_W-1:0] pick_text_byte();
    int r;
    r = $urandom_range(9);
    if (r < 5) return flip_case(pat_now[8*$urandom_range(PAT_BYTES-1) +: 8]);
    if (r < 8) return flip_case(8'(8'h61 + $urandom_range(2)));
    return 8'($urandom_range(255));
  endfunction

  // Offer one byte; idle first at random, then hold until accepted
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    if (in_idle_on && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < 38);
    end
    in_valid     <= 1'b1;
    in_text_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_ready !== 1'b1);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_text();
    foreach (text_buf[i]) send_byte(text_buf[i], i == text_buf.size() - 1);
    texts_sent++;
  endtask

  task automatic send_str(input string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    send_text();
  endtask

  // Wait until every result is out and the block has settled
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (results_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  // Write all four registers; call only while the block is idle
  task automatic load_pattern(input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
                              input logic [LEN_W-1:0] len, input logic exact);
    logic [CFG_DATA_W-1:0] len_word, mode_word;
    len_word  = {$urandom, $urandom};
    mode_word = {$urandom, $urandom};
    len_word[LEN_W-1:0] = len;
    mode_word[0] = exact;
    write_reg(REG_PATTERN_LO, lo);
    write_reg(REG_PATTERN_HI, hi);
    write_reg(REG_PATTERN_LEN, len_word);
    write_reg(REG_CASE_SENS, mode_word);
    cfg_wr_en   <= 1'b0;
    pat_now     = {hi, lo};
    pat_len_now = (len > PAT_BYTES) ? PAT_BYTES : int'(len);
  endtask

  initial begin
    logic [2*CFG_DATA_W-1:0] pat;
    logic [LEN_W-1:0]        len;
    logic                    exact;
    int                      r, span;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Zero pattern length after reset: only a miss at the last byte
    send_str("a");

    // Case folding, match before the last byte, bytes after a match
    drain();
    load_pattern(64'h5A61, {$urandom, $urandom}, 5'd2, 1'b0);
    send_str("qAz!");

    // Exact compare: a folded-only text misses, an exact one matches on its last byte
    drain();
    load_pattern(64'h5A61, {$urandom, $urandom}, 5'd2, 1'b1);
    send_str("Az");
    send_str("aZ");

    // Full-width pattern of extreme bytes, length above the maximum
    drain();
    load_pattern(64'h00FF00FF00FF00FF, 64'h00FF00FF00FF00FF, 5'd31, 1'b0);
    text_buf.delete();
    for (int i = 0; i < PAT_BYTES; i++) text_buf.push_back((i % 2 == 0) ? 8'hFF : 8'h00);
    send_text();

    // Hold the receiver off so the result buffer fills and the input stalls
    drain();
    load_pattern({{7{8'($urandom_range(255))}}, 8'h41}, {$urandom, $urandom}, 5'd1, 1'b0);
    hold_req = 1'b1;
    repeat (40) begin
      text_buf.delete();
      text_buf.push_back(pick_text_byte());
      send_text();
    end

    // Back-to-back bytes, no idling on either side
    drain();
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    load_pattern(64'h537251, {$urandom, $urandom}, 5'd3, 1'b0);
    for (int n = 0; n < NO_IDLE_BYTES; n++) send_byte(8'($urandom_range(8'h40)), 1'b0);
    send_str("qRs");
    send_str("xqrs");

    // Random phases: new pattern and mode, then a batch of texts
    while (random_bytes < RANDOM_ITEMS) begin
      drain();
      in_idle_on  = ($urandom_range(7) != 0);
      out_idle_on = ($urandom_range(7) != 0);
      for (int i = 0; i < PAT_BYTES; i++) begin
        r = $urandom_range(9);
        if (r < 6) begin
          pat[8*i +: 8] = flip_case(8'(8'h61 + $urandom_range(2)));
        end else if (r == 6) begin
          case ($urandom_range(5))
            0: pat[8*i +: 8] = 8'h40;
            1: pat[8*i +: 8] = 8'h5B;
            2: pat[8*i +: 8] = 8'h60;
            3: pat[8*i +: 8] = 8'h7B;
            4: pat[8*i +: 8] = 8'h00;
            default: pat[8*i +: 8] = 8'hFF;
          endcase
        end else begin
          pat[8*i +: 8] = 8'($urandom_range(255));
        end
      end
      r = $urandom_range(19);
      if (r == 0) len = 5'd0;
      else if (r == 1) len = 5'($urandom_range(31, 17));
      else if (r < 4) len = 5'($urandom_range(16, 7));
      else len = 5'($urandom_range(6, 1));
      exact = 1'($urandom_range(1));
      load_pattern(pat[CFG_DATA_W-1:0], pat[2*CFG_DATA_W-1:CFG_DATA_W], len, exact);

      repeat ($urandom_range(8, 2)) begin
        text_buf.delete();
        repeat ($urandom_range(12)) text_buf.push_back(pick_text_byte());
        // Whole pattern, a broken prefix, or none at all
        r = $urandom_range(9);
        if (r < 5) span = pat_len_now;
        else if (r < 7) span = $urandom_range(pat_len_now);
        else span = 0;
        for (int i = 0; i < span; i++) begin
          text_buf.push_back(($urandom_range(3) == 0) ? flip_case(pat_now[8*i +: 8])
                                                      : pat_now[8*i +: 8]);
        end
        repeat ($urandom_range(8)) text_buf.push_back(pick_text_byte());
        if (text_buf.size() == 0) text_buf.push_back(pick_text_byte());
        random_bytes += text_buf.size();
        send_text();
      end
    end

    // Let the last results out, then give the verdict
    drain();
    repeat (10) @(negedge clk);
    $display("Sent %0d texts, %0d bytes, a back-to-back stretch and a long output stall.",
             texts_sent, bytes_sent);
    $display("Checked %0d matches and %0d misses.", hit_count, miss_count);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* substring_search_with_case_mode_unit.f */
+incdir+src
src/ssc_pkg.sv
src/ssc_cell.sv
src/ssc_out_buf.sv
src/substring_search_with_case_mode_unit.sv
tb/ssc_search_checker.sv
tb/substring_search_with_case_mode_unit_tb.sv
